// ----- rtl/core/wssu_pkg.sv -----
// ----------------------------------------------------------------------------
// wssu_pkg
// Shared constants and helpers for the wheel spin state update block:
// fixed point format, divider sizing, item op codes, register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wssu_pkg;

	localparam int FRAC_BITS = 16;

	// torque sum magnitude is below 2^33, so the dividend needs 33 + FRAC_BITS bits
	localparam int DIV_W  = 33 + FRAC_BITS;
	localparam int DIV_CW = $clog2(DIV_W);

	localparam logic [2:0] OP_UPDATE    = 3'd0;
	localparam logic [2:0] OP_TRY_FWD   = 3'd1;
	localparam logic [2:0] OP_TRY_REV   = 3'd2;
	localparam logic [2:0] OP_FORCE_FWD = 3'd3;
	localparam logic [2:0] OP_FORCE_REV = 3'd4;

	localparam logic [2:0] REG_WHEEL_INERTIA = 3'd0;
	localparam logic [2:0] REG_WHEEL_RADIUS  = 3'd1;
	localparam logic [2:0] REG_MIN_SPEED     = 3'd2;
	localparam logic [2:0] REG_MOUNT_X       = 3'd3;
	localparam logic [2:0] REG_MOUNT_Y       = 3'd4;
	localparam logic [2:0] REG_EXTRA_TORQUE  = 3'd5;
	localparam logic [2:0] REG_STEP_TIME     = 3'd6;
	localparam logic [2:0] REG_NEAR_ZERO     = 3'd7;

	// sign code: {negative, nonzero}
	localparam logic [1:0] SGN_ZERO = 2'b00;
	localparam logic [1:0] SGN_POS  = 2'b01;
	localparam logic [1:0] SGN_NEG  = 2'b11;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (!v[65] && (v[64:31] != '0)) begin
			return 32'sh7FFF_FFFF;
		end else if (v[65] && (v[64:31] != '1)) begin
			return 32'sh8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

	function automatic logic [1:0] sgn32(input logic signed [31:0] v);
		if (v[31]) begin
			return SGN_NEG;
		end else if (v != '0) begin
			return SGN_POS;
		end else begin
			return SGN_ZERO;
		end
	endfunction

	// value times a sign code
	function automatic logic signed [31:0] apply_sgn(input logic [1:0] s,
		input logic signed [31:0] v);
		if (s == SGN_NEG) begin
			return -v;
		end else if (s == SGN_POS) begin
			return v;
		end else begin
			return '0;
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wheel_spin_state_update_top.sv -----
// ----------------------------------------------------------------------------
// wheel_spin_state_update_top
// Wheel angular velocity and hub velocity state update in signed Q16.16,
// built around one shared multiplier and one radix-2 divider.
// ----------------------------------------------------------------------------
// One item is taken at a time and every item returns one result. An update
// item runs three multiplier steps, 49 steps of the bit-serial divider for
// torque over inertia, four steps for the time step product and the spin
// rules, and the result load. With a zero inertia sum the divider is skipped.
// Direction items run one direction step and the result load; unknown ops go
// straight to the result load. After reset and after a write of the wheel
// radius or minimum speed register the next known item first recomputes the
// minimum spin on the same divider (the divider steps are skipped with a zero
// radius). The result sits in an output register, so a new item can be taken
// while it waits. Configuration writes are taken only while no item is in
// progress.
`timescale 1ns / 1ps
`default_nettype none

module wheel_spin_state_update_top (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         op,
	input  wire logic signed [31:0] body_vel_x,
	input  wire logic signed [31:0] body_vel_y,
	input  wire logic signed [31:0] yaw_rate,
	input  wire logic [30:0]        load_inertia,
	input  wire logic signed [31:0] drive_torque,
	input  wire logic signed [31:0] road_torque,

	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      spin_rate,
	output logic signed [31:0]      hub_x,
	output logic signed [31:0]      hub_y,

	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MS0,
		S_DIV,
		S_MS1,
		S_M1,
		S_M2,
		S_M3,
		S_DV,
		S_NW,
		S_TH,
		S_FIN,
		S_TRY,
		S_SET,
		S_OUT
	} state_t;

	state_t state_q, div_ret_q;

	// configuration
	logic [30:0]        wheel_inertia_q, wheel_radius_q, floor_speed_q;
	logic [30:0]        step_time_q, near_zero_q;
	logic signed [31:0] mount_x_q, mount_y_q, extra_torque_q;

	// item
	logic [2:0]         op_q;
	logic signed [31:0] vx_q, vy_q, yaw_q, drv_q, road_q;
	logic [30:0]        load_q;

	// state
	logic signed [31:0] spin_q, hub_x_q, hub_y_q;
	logic signed [31:0] ms_q;
	logic               ms_ok_q;
	logic signed [31:0] hx_q, nw_q;

	// result
	logic               out_valid_q;
	logic signed [31:0] spin_out_q, hub_x_out_q, hub_y_out_q;

	// multiplier
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod_q, sh;

	// divider
	logic [wssu_pkg::DIV_W-1:0]  quo_q, ld_num;
	logic [31:0]                 rem_q, den_q, ld_den;
	logic [wssu_pkg::DIV_CW-1:0] cnt_q;
	logic                        neg_q, nz_q, dz_q, ld_neg, ld_nz, div_ld;
	logic [32:0]                 rsh;
	logic                        ge;
	logic signed [31:0]          div_res;

	// datapath results
	logic signed [31:0] hx_calc, hy_calc, hub_x_upd, nw_calc, spin_fin;
	logic signed [33:0] tq_sum, tq_mag;
	logic               try_ok;

	logic in_acc, out_acc, cfg_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign cfg_acc = cfg_valid && cfg_ready;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign spin_rate = spin_out_q;
	assign hub_x     = hub_x_out_q;
	assign hub_y     = hub_y_out_q;

	function automatic state_t dispatch(input logic [2:0] o);
		case (o)
			wssu_pkg::OP_UPDATE:    return S_M1;
			wssu_pkg::OP_TRY_FWD:   return S_TRY;
			wssu_pkg::OP_TRY_REV:   return S_TRY;
			wssu_pkg::OP_FORCE_FWD: return S_SET;
			wssu_pkg::OP_FORCE_REV: return S_SET;
			default:                return S_OUT;
		endcase
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_inertia_q <= 31'd65536;
			wheel_radius_q  <= 31'd65536;
			floor_speed_q   <= 31'd6554;
			mount_x_q       <= '0;
			mount_y_q       <= '0;
			extra_torque_q  <= '0;
			step_time_q     <= 31'd1092;
			near_zero_q     <= 31'd66;
		end else if (cfg_acc) begin
			case (cfg_index)
				wssu_pkg::REG_WHEEL_INERTIA: wheel_inertia_q <= cfg_data[30:0];
				wssu_pkg::REG_WHEEL_RADIUS:  wheel_radius_q  <= cfg_data[30:0];
				wssu_pkg::REG_MIN_SPEED:     floor_speed_q   <= cfg_data[30:0];
				wssu_pkg::REG_MOUNT_X:       mount_x_q       <= cfg_data;
				wssu_pkg::REG_MOUNT_Y:       mount_y_q       <= cfg_data;
				wssu_pkg::REG_EXTRA_TORQUE:  extra_torque_q  <= cfg_data;
				wssu_pkg::REG_STEP_TIME:     step_time_q     <= cfg_data[30:0];
				wssu_pkg::REG_NEAR_ZERO:     near_zero_q     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_M1: begin
				ma = yaw_q;
				mb = mount_y_q;
			end
			S_M2: begin
				ma = yaw_q;
				mb = mount_x_q;
			end
			S_DV: begin
				ma = div_res;
				mb = $signed({1'b0, step_time_q});
			end
			S_TH: begin
				ma = nw_q;
				mb = $signed({1'b0, wheel_radius_q});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(ma) * 64'(mb);
	end

	// floor-rounded q product
	assign sh = prod_q >>> wssu_pkg::FRAC_BITS;

	// divider load select
	always_comb begin
		tq_sum = 34'(drv_q) + 34'(road_q) + 34'(extra_torque_q);
		tq_mag = tq_sum[33] ? -tq_sum : tq_sum;
		div_ld = (state_q == S_MS0) || (state_q == S_M3);
		if (state_q == S_MS0) begin
			ld_num = wssu_pkg::DIV_W'(floor_speed_q) << wssu_pkg::FRAC_BITS;
			ld_den = {1'b0, wheel_radius_q};
			ld_neg = 1'b0;
			ld_nz  = (floor_speed_q != '0);
		end else begin
			ld_num = wssu_pkg::DIV_W'(tq_mag[32:0]) << wssu_pkg::FRAC_BITS;
			ld_den = 32'({1'b0, load_q}) + 32'({1'b0, wheel_inertia_q});
			ld_neg = tq_sum[33];
			ld_nz  = (tq_sum != '0);
		end
	end

	// restoring division step
	assign rsh = {rem_q, quo_q[wssu_pkg::DIV_W-1]};
	assign ge  = (rsh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (div_ld) begin
			cnt_q <= '0;
		end else if (state_q == S_DIV) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ld) begin
			quo_q <= ld_num;
			rem_q <= '0;
			den_q <= ld_den;
			neg_q <= ld_neg;
			nz_q  <= ld_nz;
			dz_q  <= (ld_den == '0);
		end else if (state_q == S_DIV) begin
			quo_q <= {quo_q[wssu_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? 32'(rsh - {1'b0, den_q}) : rsh[31:0];
		end
	end

	// truncated quotient, saturated
	always_comb begin
		if (dz_q) begin
			div_res = neg_q ? 32'sh8000_0000 : (nz_q ? 32'sh7FFF_FFFF : 32'sh0);
		end else if (neg_q) begin
			if (quo_q > wssu_pkg::DIV_W'(33'h0_8000_0000)) begin
				div_res = 32'sh8000_0000;
			end else begin
				div_res = 32'(-quo_q);
			end
		end else if (quo_q > wssu_pkg::DIV_W'(32'h7FFF_FFFF)) begin
			div_res = 32'sh7FFF_FFFF;
		end else begin
			div_res = quo_q[31:0];
		end
	end

	// update and direction arithmetic
	always_comb begin
		logic [32:0]        hmag, smag;
		logic signed [33:0] hdiff, hdmag;
		logic [1:0]         s_new;
		logic signed [63:0] th;
		logic [63:0]        thmag;
		logic [1:0]         th_sgn;
		logic signed [31:0] ms_signed;

		hx_calc = wssu_pkg::sat32(66'(vx_q) - 66'(sh));
		hy_calc = wssu_pkg::sat32(66'(vy_q) + 66'(sh));
		nw_calc = wssu_pkg::sat32(66'(spin_q) + 66'(sh));

		// hub x keeps its direction and at least min speed
		hmag = hx_q[31] ? 33'(-33'(hx_q)) : 33'(hx_q);
		if ((wssu_pkg::sgn32(hx_q) != wssu_pkg::sgn32(hub_x_q))
			|| (hmag < {2'b0, floor_speed_q})) begin
			hub_x_upd = wssu_pkg::apply_sgn(wssu_pkg::sgn32(hub_x_q),
				$signed({1'b0, floor_speed_q}));
		end else begin
			hub_x_upd = hx_q;
		end

		// spin rules after integration
		s_new  = wssu_pkg::sgn32(hub_x_q);
		th     = sh;
		thmag  = th[63] ? 64'(-th) : 64'(th);
		th_sgn = th[63] ? wssu_pkg::SGN_NEG :
			((th != '0) ? wssu_pkg::SGN_POS : wssu_pkg::SGN_ZERO);
		if ($signed(33'(vx_q)) < $signed({2'b0, near_zero_q})) begin
			if ((thmag < {33'b0, floor_speed_q}) || (th_sgn != s_new)) begin
				spin_fin = wssu_pkg::apply_sgn(s_new, ms_q);
			end else begin
				spin_fin = nw_q;
			end
		end else if (s_new != wssu_pkg::sgn32(nw_q)) begin
			spin_fin = '0;
		end else begin
			spin_fin = nw_q;
		end

		// near minimum speed test for try items
		hmag      = hub_x_q[31] ? 33'(-33'(hub_x_q)) : 33'(hub_x_q);
		hdiff     = $signed({1'b0, hmag}) - $signed({3'b0, floor_speed_q});
		hdmag     = hdiff[33] ? -hdiff : hdiff;
		smag      = spin_q[31] ? 33'(-33'(spin_q)) : 33'(spin_q);
		ms_signed = ms_q;
		try_ok    = (hdmag < $signed({3'b0, near_zero_q}))
			&& (smag <= 33'(ms_signed));
	end

	// sequencer, state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_ret_q   <= S_IDLE;
			op_q        <= wssu_pkg::OP_UPDATE;
			vx_q        <= '0;
			vy_q        <= '0;
			yaw_q       <= '0;
			load_q      <= '0;
			drv_q       <= '0;
			road_q      <= '0;
			spin_q      <= '0;
			hub_x_q     <= '0;
			hub_y_q     <= '0;
			ms_q        <= '0;
			ms_ok_q     <= 1'b0;
			hx_q        <= '0;
			nw_q        <= '0;
			out_valid_q <= 1'b0;
			spin_out_q  <= '0;
			hub_x_out_q <= '0;
			hub_y_out_q <= '0;
		end else begin
			if (out_acc && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_acc && ((cfg_index == wssu_pkg::REG_WHEEL_RADIUS)
				|| (cfg_index == wssu_pkg::REG_MIN_SPEED))) begin
				ms_ok_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q   <= op;
						vx_q   <= body_vel_x;
						vy_q   <= body_vel_y;
						yaw_q  <= yaw_rate;
						load_q <= load_inertia;
						drv_q  <= drive_torque;
						road_q <= road_torque;
						if (op > wssu_pkg::OP_FORCE_REV) begin
							state_q <= S_OUT;
						end else if (!ms_ok_q) begin
							state_q <= S_MS0;
						end else begin
							state_q <= dispatch(op);
						end
					end
				end
				S_MS0: begin
					div_ret_q <= S_MS1;
					state_q   <= (ld_den == '0) ? S_MS1 : S_DIV;
				end
				S_DIV: begin
					if (cnt_q == wssu_pkg::DIV_CW'(wssu_pkg::DIV_W - 1)) begin
						state_q <= div_ret_q;
					end
				end
				S_MS1: begin
					ms_q    <= div_res;
					ms_ok_q <= 1'b1;
					state_q <= dispatch(op_q);
				end
				S_M1: begin
					state_q <= S_M2;
				end
				S_M2: begin
					hx_q    <= hx_calc;
					state_q <= S_M3;
				end
				S_M3: begin
					hub_x_q   <= hub_x_upd;
					hub_y_q   <= hy_calc;
					div_ret_q <= S_DV;
					state_q   <= (ld_den == '0) ? S_DV : S_DIV;
				end
				S_DV: begin
					state_q <= S_NW;
				end
				S_NW: begin
					nw_q    <= nw_calc;
					state_q <= S_TH;
				end
				S_TH: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					spin_q  <= spin_fin;
					state_q <= S_OUT;
				end
				S_TRY: begin
					if (try_ok) begin
						spin_q  <= (op_q == wssu_pkg::OP_TRY_REV) ? -ms_q : ms_q;
						hub_x_q <= (op_q == wssu_pkg::OP_TRY_REV) ?
							-$signed({1'b0, floor_speed_q}) : $signed({1'b0, floor_speed_q});
					end
					state_q <= S_OUT;
				end
				S_SET: begin
					spin_q  <= (op_q == wssu_pkg::OP_FORCE_REV) ? -ms_q : ms_q;
					hub_x_q <= (op_q == wssu_pkg::OP_FORCE_REV) ?
						-$signed({1'b0, floor_speed_q}) : $signed({1'b0, floor_speed_q});
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						spin_out_q  <= spin_q;
						hub_x_out_q <= hub_x_q;
						hub_y_out_q <= hub_y_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// accepted item keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("block not busy after taking an item");

	// divider runs its full step count
	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && (cnt_q != wssu_pkg::DIV_CW'(wssu_pkg::DIV_W - 1))
		|=> (state_q == S_DIV))
		else $error("divider left before its last step");

	// minimum spin is marked good once computed
	a_ms_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MS1) |=> ms_ok_q)
		else $error("minimum spin not marked valid");

	// a result only appears from the result load
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result valid without result load");

endmodule

`default_nettype wire
